// ===== rtl/shfc_pkg.sv =====
// Shared constants for the single/half float converter.
package shfc_pkg;

  localparam int SINGLE_W = 32;
  localparam int HALF_W   = 16;

  // Direction select codes
  localparam logic FUNC_S2H = 1'b0;
  localparam logic FUNC_H2S = 1'b1;

  // Single-precision field constants
  localparam logic [7:0]  S_EXP_MAX     = 8'hFF;
  localparam logic [7:0]  S_EXP_OVF     = 8'd143;  // half exponent would be >= 31
  localparam logic [7:0]  S_EXP_SUB_TOP = 8'd112;  // half exponent <= 0
  localparam logic [7:0]  S_EXP_SUB_MIN = 8'd102;  // below this, even the round bit is gone
  localparam logic [7:0]  S_SUB_SHIFT   = 8'd126;
  localparam logic [7:0]  EXP_REBIAS    = 8'd112;
  localparam logic [7:0]  H_SUB_EXP     = 8'd113;

  localparam logic [14:0] HALF_INF_MAG   = 15'h7C00;
  localparam logic [15:0] HALF_NAN       = 16'hFE00;
  localparam logic [30:0] SINGLE_INF_MAG = 31'h7F800000;
  localparam logic [31:0] SINGLE_NAN     = 32'hFFC00000;

endpackage

// ===== rtl/shfc_s2h.sv =====
// Single-to-half conversion datapath, round on first dropped bit.
module shfc_s2h (
  input  logic [shfc_pkg::SINGLE_W-1:0] single_bits,
  output logic [shfc_pkg::HALF_W-1:0]   half_bits
);

  logic        sgn;
  logic [7:0]  ex;
  logic [22:0] man;
  logic [23:0] full;
  logic [4:0]  sh;
  logic [23:0] sub_q;
  logic [23:0] sub_q_rnd;
  logic [10:0] sub_mag;
  logic [4:0]  hexp;
  logic [14:0] norm_mag;

  always_comb begin
    sgn  = single_bits[31];
    ex   = single_bits[30:23];
    man  = single_bits[22:0];
    full = {1'b1, man};

    // subnormal path: shift of 14..24 when used
    sh        = 5'(shfc_pkg::S_SUB_SHIFT - ex);
    sub_q     = full >> sh;
    sub_q_rnd = full >> (sh - 5'd1);
    sub_mag   = sub_q[10:0] + {10'd0, sub_q_rnd[0]};

    // normal path; a carry may ripple up to infinity
    hexp     = 5'(ex - shfc_pkg::EXP_REBIAS);
    norm_mag = {hexp, man[22:13]} + {14'd0, man[12]};

    if (ex == 8'd0) begin
      half_bits = {sgn, 15'd0};
    end else if (ex == shfc_pkg::S_EXP_MAX) begin
      half_bits = (man == 23'd0) ? {sgn, shfc_pkg::HALF_INF_MAG} : shfc_pkg::HALF_NAN;
    end else if (ex >= shfc_pkg::S_EXP_OVF) begin
      half_bits = {sgn, shfc_pkg::HALF_INF_MAG};
    end else if (ex <= shfc_pkg::S_EXP_SUB_TOP) begin
      if (ex >= shfc_pkg::S_EXP_SUB_MIN) begin
        half_bits = {sgn, 4'd0, sub_mag};
      end else begin
        half_bits = {sgn, 15'd0};
      end
    end else begin
      half_bits = {sgn, norm_mag};
    end
  end

endmodule

// ===== rtl/shfc_h2s.sv =====
// Half-to-single conversion datapath with leading-zero normalize.
module shfc_h2s (
  input  logic [shfc_pkg::HALF_W-1:0]   half_bits,
  output logic [shfc_pkg::SINGLE_W-1:0] single_bits
);

  logic        sgn;
  logic [4:0]  ex;
  logic [9:0]  man;
  logic [3:0]  msb;
  logic [3:0]  lz;
  logic [10:0] norm;
  logic [7:0]  sub_exp;

  always_comb begin
    sgn = half_bits[15];
    ex  = half_bits[14:10];
    man = half_bits[9:0];

    // highest set bit of the subnormal mantissa
    msb = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) msb = 4'(i);
    end
    lz      = 4'd10 - msb;
    norm    = {1'b0, man} << lz;
    sub_exp = shfc_pkg::H_SUB_EXP - {4'd0, lz};

    if (half_bits[14:0] == 15'd0) begin
      single_bits = {sgn, 31'd0};
    end else if (ex == 5'd0) begin
      single_bits = {sgn, sub_exp, norm[9:0], 13'd0};
    end else if (ex == 5'h1F) begin
      single_bits = (man == 10'd0) ? {sgn, shfc_pkg::SINGLE_INF_MAG} : shfc_pkg::SINGLE_NAN;
    end else begin
      single_bits = {sgn, {3'd0, ex} + shfc_pkg::EXP_REBIAS, man, 13'd0};
    end
  end

endmodule

// ===== rtl/single_half_float_converter_top.sv =====
// Single/half precision float bit converter, top level.
//
// Command interface: a word is taken at each rising edge with start high
// and busy low. busy is never raised, so a word may be issued every cycle.
// in_func selects the direction (0 single-to-half, 1 half-to-single);
// in_operand_bits holds single bits, or half bits in the low 16 bits.
// The converted word passes through the input register, the conversion
// logic and the result register to out_result_bits, flagged by out_valid
// for exactly one cycle; a half result sits in the low 16 bits with the
// upper bits zero.
// Throughput: 1 word per cycle, set by the single pass through the
// conversion logic between the two registers.
// Reset (synchronous, rst_n low) drops any word in flight and clears
// out_valid. The receiver cannot stall: every result must be taken on the
// cycle it is shown.
module single_half_float_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [31:0] in_operand_bits,
  output logic        out_valid,
  output logic [31:0] out_result_bits
);

  logic        in_vld_r;
  logic        in_func_r;
  logic [31:0] in_op_r;
  logic        out_vld_r;
  logic [31:0] out_res_r;
  logic [31:0] out_res_nxt;
  logic [15:0] s2h_res;
  logic [31:0] h2s_res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_func_r <= in_func;
      in_op_r   <= in_operand_bits;
    end
    if (in_vld_r) begin
      out_res_r <= out_res_nxt;
    end
  end

  shfc_s2h u_s2h (
    .single_bits (in_op_r),
    .half_bits   (s2h_res)
  );

  shfc_h2s u_h2s (
    .half_bits   (in_op_r[15:0]),
    .single_bits (h2s_res)
  );

  assign out_res_nxt = (in_func_r == shfc_pkg::FUNC_H2S) ? h2s_res : {16'd0, s2h_res};

  assign out_valid       = out_vld_r;
  assign out_result_bits = out_res_r;

endmodule

// ===== rtl/shfc_checker.sv =====
// Port-level checker for the converter top, bound onto it.
module shfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_func,
  input logic [31:0] in_operand_bits,
  input logic        out_valid,
  input logic [31:0] out_result_bits
);

  // every accepted word shows up on out_valid after the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted word did not produce a result after 2 cycles");

  // no result without a word taken earlier through the input and result registers
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##2 !out_valid)
    else $error("result word without a matching command");

  // half results keep the upper bits clear
  a_half_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == shfc_pkg::FUNC_S2H) |-> ##2 (out_result_bits[31:16] == 16'd0))
    else $error("single-to-half result has nonzero upper bits");

  // half signed zero widens to single signed zero
  a_h2s_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == shfc_pkg::FUNC_H2S && in_operand_bits[14:0] == 15'd0)
    |-> ##2 (out_result_bits[30:0] == 31'd0 &&
             out_result_bits[31] == $past(in_operand_bits[15], 2)))
    else $error("half zero not converted to signed single zero");

endmodule

bind single_half_float_converter_top shfc_checker u_shfc_checker (.*);
